/* hdl/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg - shared constants for the run-length / back-reference decompressor
// command byte boundaries, length biases, decode phases and register map
// ----------------------------------------------------------------------------
package rbd_pkg;

    // default sizing
    localparam int HISTORY_DEPTH_DEF = 512;
    localparam int SIZE_BITS_DEF     = 24;
    localparam int BEAT_BYTES_DEF    = 8;

    // fixed port widths
    localparam int BYTE_BITS   = 8;
    localparam int DATA_BITS   = 64;
    localparam int COUNT_BITS  = 4;
    localparam int LEN_BITS    = 7;
    localparam int DIST_BITS   = 9;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;
    localparam int M_DATA_BITS = 72;

    // command byte classes
    localparam logic [7:0] CMD_ZERO_BASE = 8'h40;
    localparam logic [7:0] CMD_RUN_BASE  = 8'h80;
    localparam logic [7:0] CMD_COPY_BASE = 8'hC0;
    localparam logic [7:0] CMD_NOP       = 8'hFE;
    localparam logic [7:0] CMD_END       = 8'hFF;

    // length and distance biases
    localparam logic [7:0] ZERO_BIAS = 8'd62;
    localparam logic [7:0] RUN_BIAS  = 8'd126;
    localparam logic [7:0] COPY_BIAS = 8'd190;
    localparam logic [8:0] DIST_BIAS = 9'd2;

    // decode phase between compressed bytes
    localparam logic [1:0] PH_COMMAND = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_RUNBYTE = 2'd2;
    localparam logic [1:0] PH_OFFSET  = 2'd3;

    // register index (paddr[2])
    localparam logic REG_EXPECTED_SIZE = 1'b0;

endpackage

/* hdl/rle_backref_byte_decompressor.sv */
// ----------------------------------------------------------------------------
// rle_backref_byte_decompressor - hybrid run-length / back-reference decoder
// takes one compressed byte per beat, emits up to BEAT_BYTES output bytes
// per beat and keeps the recent output in a history memory for copies
// ----------------------------------------------------------------------------
//
//  channel   | direction | contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tdata: in_byte[7:0]; tuser: stream_start[0]
//  m_axis    | out       | tdata: out_data[63:0], byte_count[67:64];
//            |           | tlast: run_last; tuser: stream_end[0], fault[1]
//  apb       | cfg       | reg 0 at 0x0: expected_size
//
//  a compressed byte is accepted only while the engine is idle; the engine then
//  writes its output bytes one per cycle unless the output register stalls it,
//  or a status-only beat if it produces none, before it takes the next byte.
//  history memory: one write and one read a cycle; one byte per cycle, also for copy reads.
//  reset clears decode state but fill, copy, dist and beat data; history is left as it is.
//  a full output register stalls the engine only when a beat must leave.
//
module rle_backref_byte_decompressor #(
    parameter int HISTORY_DEPTH = rbd_pkg::HISTORY_DEPTH_DEF,
    parameter int SIZE_BITS     = rbd_pkg::SIZE_BITS_DEF,
    parameter int BEAT_BYTES    = rbd_pkg::BEAT_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rbd_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [rbd_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [rbd_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    // compressed input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbd_pkg::BYTE_BITS-1:0]     s_tdata,   // in_byte[7:0]
    input  logic [0:0]                        s_tuser,   // stream_start[0]
    // decompressed output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbd_pkg::M_DATA_BITS-1:0]   m_tdata,   // out_data[63:0], byte_count[67:64]
    output logic                              m_tlast,
    output logic [1:0]                        m_tuser    // stream_end[0], fault[1]
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int LB = rbd_pkg::LEN_BITS;
    localparam int DB = rbd_pkg::DIST_BITS;

    // engine states
    localparam logic ENG_IDLE = 1'b0;
    localparam logic ENG_RUN  = 1'b1;

    // ---------------------------------------------------------------- config
    logic [SIZE_BITS-1:0] exp_size_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rbd_pkg::REG_EXPECTED_SIZE)
                    ? rbd_pkg::PDATA_BITS'(exp_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_size_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == rbd_pkg::REG_EXPECTED_SIZE)
        begin
            exp_size_reg <= pwdata[SIZE_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------- state
    logic                 eng_reg,       eng_next;
    logic [1:0]           phase_reg,     phase_next;
    logic [LB-1:0]        remlit_reg,    remlit_next;
    logic [LB-1:0]        pend_reg,      pend_next;
    logic                 ended_reg,     ended_next;
    logic                 faulted_reg,   faulted_next;
    logic [AW-1:0]        wp_reg,        wp_next;
    logic [SIZE_BITS-1:0] prod_reg,      prod_next;
    // burst of output bytes for the current compressed byte
    logic [LB-1:0]        left_reg,      left_next;
    logic [7:0]           fill_reg,      fill_next;
    logic                 copy_reg,      copy_next;
    logic [DB-1:0]        dist_reg,      dist_next;
    // beat being assembled
    logic [63:0]          beat_data_reg, beat_data_next;
    logic [3:0]           beat_cnt_reg,  beat_cnt_next;
    // output register
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic [3:0]           out_cnt_reg;
    logic                 out_last_reg;
    logic                 out_end_reg;
    logic                 out_fault_reg;

    // history memory
    logic [7:0]           hist_mem [HISTORY_DEPTH];
    logic [7:0]           rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [7:0]           mem_wdata;

    // push into output register
    logic                 push;
    logic [63:0]          push_data;
    logic [3:0]           push_cnt;
    logic                 push_last;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (eng_reg == ENG_IDLE);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_cnt_reg, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_fault_reg, out_end_reg};

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        logic [1:0]           ph_e;
        logic [LB-1:0]        remlit_e;
        logic [LB-1:0]        pend_e;
        logic                 ended_e;
        logic                 faulted_e;
        logic [AW-1:0]        wp_e;
        logic [SIZE_BITS-1:0] prod_e;
        logic [7:0]           x;
        logic [LB-1:0]        n;
        logic [SIZE_BITS-1:0] room;
        logic [LB-1:0]        m;
        logic [DB-1:0]        copy_dist;
        logic [7:0]           b;
        logic [63:0]          beat_after;
        logic [3:0]           cnt_after;
        logic                 last;
        logic                 need_push;
        logic [AW-1:0]        dist_a;
        logic [AW:0]          wrap_sum;

        eng_next       = eng_reg;
        phase_next     = phase_reg;
        remlit_next    = remlit_reg;
        pend_next      = pend_reg;
        ended_next     = ended_reg;
        faulted_next   = faulted_reg;
        wp_next        = wp_reg;
        prod_next      = prod_reg;
        left_next      = left_reg;
        fill_next      = fill_reg;
        copy_next      = copy_reg;
        dist_next      = dist_reg;
        beat_data_next = beat_data_reg;
        beat_cnt_next  = beat_cnt_reg;
        push           = 1'b0;
        push_data      = beat_data_reg;
        push_cnt       = beat_cnt_reg;
        push_last      = 1'b0;
        mem_we         = 1'b0;

        x          = s_tdata;
        n          = '0;
        copy_dist  = {1'b0, x} + rbd_pkg::DIST_BIAS;
        room       = '0;
        m          = '0;
        b          = copy_reg ? rd_data_reg : fill_reg;
        mem_wdata  = b;
        beat_after = beat_data_reg;
        cnt_after  = beat_cnt_reg + 4'd1;
        last       = (left_reg == LB'(1));

        // stream_start restarts the decoder before this byte
        if (s_tuser[0])
        begin
            ph_e      = rbd_pkg::PH_COMMAND;
            remlit_e  = '0;
            pend_e    = '0;
            ended_e   = 1'b0;
            faulted_e = 1'b0;
            wp_e      = '0;
            prod_e    = '0;
        end
        else
        begin
            ph_e      = phase_reg;
            remlit_e  = remlit_reg;
            pend_e    = pend_reg;
            ended_e   = ended_reg;
            faulted_e = faulted_reg;
            wp_e      = wp_reg;
            prod_e    = prod_reg;
        end

        for (int i = 0; i < 8; i++)
        begin
            if (i < BEAT_BYTES && beat_cnt_reg == 4'(i))
            begin
                beat_after[8*i +: 8] = b;
            end
        end
        need_push = (cnt_after == 4'(BEAT_BYTES)) || last;

        if (eng_reg == ENG_IDLE)
        begin
            if (s_tvalid)
            begin
                phase_next   = ph_e;
                remlit_next  = remlit_e;
                pend_next    = pend_e;
                ended_next   = ended_e;
                wp_next      = wp_e;
                fill_next    = x;
                copy_next    = 1'b0;
                dist_next    = copy_dist;
                if (!ended_e)
                begin
                    case (ph_e)
                        rbd_pkg::PH_LITERAL:
                        begin
                            n = LB'(1);
                            if (remlit_e != '0)
                            begin
                                remlit_next = remlit_e - LB'(1);
                            end
                            if (remlit_e <= LB'(1))
                            begin
                                phase_next = rbd_pkg::PH_COMMAND;
                            end
                        end
                        rbd_pkg::PH_RUNBYTE:
                        begin
                            n          = pend_e;
                            pend_next  = '0;
                            phase_next = rbd_pkg::PH_COMMAND;
                        end
                        rbd_pkg::PH_OFFSET:
                        begin
                            // reference before the start of the stream
                            if (SIZE_BITS'(copy_dist) > prod_e)
                            begin
                                faulted_e = 1'b1;
                            end
                            else
                            begin
                                n = pend_e;
                            end
                            copy_next  = 1'b1;
                            pend_next  = '0;
                            phase_next = rbd_pkg::PH_COMMAND;
                        end
                        default:
                        begin
                            if (x < rbd_pkg::CMD_ZERO_BASE)
                            begin
                                remlit_next = LB'(x) + LB'(1);
                                phase_next  = rbd_pkg::PH_LITERAL;
                            end
                            else if (x < rbd_pkg::CMD_RUN_BASE)
                            begin
                                n         = LB'(x - rbd_pkg::ZERO_BIAS);
                                fill_next = 8'h00;
                            end
                            else if (x < rbd_pkg::CMD_COPY_BASE)
                            begin
                                pend_next  = LB'(x - rbd_pkg::RUN_BIAS);
                                phase_next = rbd_pkg::PH_RUNBYTE;
                            end
                            else if (x < rbd_pkg::CMD_NOP)
                            begin
                                pend_next  = LB'(x - rbd_pkg::COPY_BIAS);
                                phase_next = rbd_pkg::PH_OFFSET;
                            end
                            else if (x == rbd_pkg::CMD_END)
                            begin
                                ended_next = 1'b1;
                            end
                        end
                    endcase
                end
                // bytes past expected_size are dropped and flag a fault
                room = (prod_e >= exp_size_reg) ? '0 : exp_size_reg - prod_e;
                if (room < SIZE_BITS'(n))
                begin
                    m         = room[LB-1:0];
                    faulted_e = 1'b1;
                end
                else
                begin
                    m = n;
                end
                faulted_next   = faulted_e;
                prod_next      = prod_e + SIZE_BITS'(m);
                left_next      = m;
                beat_data_next = '0;
                beat_cnt_next  = '0;
                eng_next       = ENG_RUN;
            end
        end
        else
        begin
            if (left_reg == '0)
            begin
                // nothing produced: status-only beat
                if (out_free)
                begin
                    push      = 1'b1;
                    push_data = '0;
                    push_cnt  = '0;
                    push_last = 1'b1;
                    eng_next  = ENG_IDLE;
                end
            end
            else if (!need_push || out_free)
            begin
                mem_we    = 1'b1;
                wp_next   = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                left_next = left_reg - LB'(1);
                if (need_push)
                begin
                    push           = 1'b1;
                    push_data      = beat_after;
                    push_cnt       = cnt_after;
                    push_last      = last;
                    beat_data_next = '0;
                    beat_cnt_next  = '0;
                    if (last)
                    begin
                        eng_next = ENG_IDLE;
                    end
                end
                else
                begin
                    beat_data_next = beat_after;
                    beat_cnt_next  = cnt_after;
                end
            end
        end

        // copy source for the next byte; dist >= 2 keeps it clear of the write
        dist_a   = AW'(dist_next);
        wrap_sum = {1'b0, wp_next} + (AW+1)'(HISTORY_DEPTH) - {1'b0, dist_a};
        rd_addr  = (wp_next >= dist_a) ? wp_next - dist_a : wrap_sum[AW-1:0];
    end

    // ---------------------------------------------------------------- memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[wp_reg] <= mem_wdata;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg      <= ENG_IDLE;
            phase_reg    <= rbd_pkg::PH_COMMAND;
            remlit_reg   <= '0;
            pend_reg     <= '0;
            ended_reg    <= 1'b0;
            faulted_reg  <= 1'b0;
            wp_reg       <= '0;
            prod_reg     <= '0;
            left_reg     <= '0;
            beat_cnt_reg <= '0;
        end
        else
        begin
            eng_reg      <= eng_next;
            phase_reg    <= phase_next;
            remlit_reg   <= remlit_next;
            pend_reg     <= pend_next;
            ended_reg    <= ended_next;
            faulted_reg  <= faulted_next;
            wp_reg       <= wp_next;
            prod_reg     <= prod_next;
            left_reg     <= left_next;
            beat_cnt_reg <= beat_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg      <= fill_next;
        copy_reg      <= copy_next;
        dist_reg      <= dist_next;
        beat_data_reg <= beat_data_next;
        if (push)
        begin
            out_data_reg  <= push_data;
            out_cnt_reg   <= push_cnt;
            out_last_reg  <= push_last;
            out_end_reg   <= ended_reg;
            out_fault_reg <= faulted_reg;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

/* dv/rle_backref_byte_decompressor_test.sv */
// ----------------------------------------------------------------------------
// rle_backref_byte_decompressor_test - self-checking bench for the decompressor
// feeds compressed byte streams with random gaps on both sides, decodes every
// byte in a behavioral decoder of its own and checks each output beat as it
// leaves, field by field, against the oldest predicted beat
// ----------------------------------------------------------------------------
module rle_backref_byte_decompressor_test;

    // run length guard: about 250 bytes at the worst engine time, nine beats
    // each behind a receiver stall and a sender gap, taken ~6x over
    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_BYTES = 50;
    localparam int MAX_REPORTS  = 10;
    localparam logic [23:0] SIZE_MAX = 24'hFFFFFF;

    // one predicted output beat
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        ended;
        logic        fault;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [rbd_pkg::PADDR_BITS-1:0]   paddr;
    logic [rbd_pkg::PDATA_BITS-1:0]   pwdata;
    logic [rbd_pkg::PDATA_BITS-1:0]   prdata;
    logic                             pready;

    logic                             s_tvalid;
    logic                             s_tready;
    logic [rbd_pkg::BYTE_BITS-1:0]    s_tdata;   // in_byte[7:0]
    logic [0:0]                       s_tuser;   // stream_start[0]

    logic                             m_tvalid;
    logic                             m_tready;
    logic [rbd_pkg::M_DATA_BITS-1:0]  m_tdata;   // out_data[63:0], byte_count[67:64]
    logic                             m_tlast;
    logic [1:0]                       m_tuser;   // stream_end[0], fault[1]

    // decoder state mirrored by the bench
    logic [7:0]  dec_hist [0:rbd_pkg::HISTORY_DEPTH_DEF-1];
    logic [8:0]  dec_wptr     = '0;
    logic [23:0] dec_produced = '0;
    logic [1:0]  dec_phase    = rbd_pkg::PH_COMMAND;
    logic [6:0]  dec_rem      = '0;
    logic [6:0]  dec_pend     = '0;
    logic        dec_ended    = 1'b0;
    logic        dec_faulted  = 1'b0;
    logic [23:0] dec_size     = '0;

    logic [7:0]  step_bytes [$];     // bytes produced by the byte being decoded
    beat_t       pending_beats [$];  // predicted beats not yet seen on m_axis
    beat_t       oldest;

    // stimulus control shared by the sender, the receiver and the tests
    bit          no_idle     = 1'b0;
    bit          hold_req    = 1'b0;
    bit          stream_head = 1'b0;
    bit          broken_mode = 1'b0;

    int          n_mismatch      = 0;
    int          n_bytes         = 0;
    int          n_beats         = 0;
    int          n_streams       = 0;
    int          n_fault_streams = 0;
    int          n_sizes         = 0;
    int          n_holds         = 0;

    rle_backref_byte_decompressor i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    // run lengths: mostly short, sometimes anywhere up to the command's limit
    function automatic int pick_len(input int hi);
        if ($urandom_range(0, 6) != 0)
            return $urandom_range(2, 10);
        return $urandom_range(2, hi);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // one output byte of the decoder, dropped once the size limit is reached
    task automatic emit_byte(input logic [7:0] v);
        if (dec_produced >= dec_size)
            dec_faulted = 1'b1;
        else
        begin
            dec_hist[dec_wptr] = v;
            dec_wptr = dec_wptr + 9'd1;
            dec_produced = dec_produced + 24'd1;
            step_bytes.push_back(v);
        end
    endtask

    // decode one accepted compressed byte and queue the beats it must cause
    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [8:0] copy_dist;
        logic [8:0] idx;
        logic       was_faulted;
        beat_t      e;
        int         n;
        int         i;
        int         k;
        int         pos;
        int         beats;
        step_bytes.delete();
        if (start)
        begin
            dec_wptr = '0;
            dec_produced = '0;
            dec_phase = rbd_pkg::PH_COMMAND;
            dec_rem = '0;
            dec_pend = '0;
            dec_ended = 1'b0;
            dec_faulted = 1'b0;
            n_streams++;
        end
        was_faulted = dec_faulted;
        if (!dec_ended)
        begin
            case (dec_phase)
                rbd_pkg::PH_LITERAL:
                begin
                    emit_byte(b);
                    if (dec_rem > 0)
                        dec_rem = dec_rem - 7'd1;
                    if (dec_rem == 0)
                        dec_phase = rbd_pkg::PH_COMMAND;
                end
                rbd_pkg::PH_RUNBYTE:
                begin
                    for (i = 0; i < dec_pend; i++)
                        emit_byte(b);
                    dec_pend = '0;
                    dec_phase = rbd_pkg::PH_COMMAND;
                end
                rbd_pkg::PH_OFFSET:
                begin
                    copy_dist = b + rbd_pkg::DIST_BIAS;
                    // a copy reaching before the stream start emits nothing
                    if (copy_dist > dec_produced)
                        dec_faulted = 1'b1;
                    else
                    begin
                        // read point moves with the write point: overlaps repeat
                        for (i = 0; i < dec_pend; i++)
                        begin
                            idx = dec_wptr - copy_dist;
                            emit_byte(dec_hist[idx]);
                        end
                    end
                    dec_pend = '0;
                    dec_phase = rbd_pkg::PH_COMMAND;
                end
                default:
                begin
                    if (b < rbd_pkg::CMD_ZERO_BASE)
                    begin
                        dec_rem = 7'(b) + 7'd1;
                        dec_phase = rbd_pkg::PH_LITERAL;
                    end
                    else if (b < rbd_pkg::CMD_RUN_BASE)
                    begin
                        n = int'(b - rbd_pkg::ZERO_BIAS);
                        for (i = 0; i < n; i++)
                            emit_byte(8'd0);
                    end
                    else if (b < rbd_pkg::CMD_COPY_BASE)
                    begin
                        dec_pend = 7'(b - rbd_pkg::RUN_BIAS);
                        dec_phase = rbd_pkg::PH_RUNBYTE;
                    end
                    else if (b < rbd_pkg::CMD_NOP)
                    begin
                        dec_pend = 7'(b - rbd_pkg::COPY_BIAS);
                        dec_phase = rbd_pkg::PH_OFFSET;
                    end
                    else if (b == rbd_pkg::CMD_END)
                        dec_ended = 1'b1;
                end
            endcase
        end
        if (dec_faulted && !was_faulted)
            n_fault_streams++;

        // pack into beats, a lone status beat when nothing was produced
        n = step_bytes.size();
        beats = (n == 0) ? 1 : (n + rbd_pkg::BEAT_BYTES_DEF - 1) / rbd_pkg::BEAT_BYTES_DEF;
        for (i = 0; i < beats; i++)
        begin
            e = '0;
            for (k = 0; k < rbd_pkg::BEAT_BYTES_DEF; k++)
            begin
                pos = i * rbd_pkg::BEAT_BYTES_DEF + k;
                if (pos < n)
                begin
                    e.data[8*k +: 8] = step_bytes[pos];
                    e.count = e.count + 4'd1;
                end
            end
            e.last = (i == beats - 1);
            e.ended = dec_ended;
            e.fault = dec_faulted;
            pending_beats.push_back(e);
        end
    endtask

    // offer one compressed byte, hold it until taken, then decode it
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        bit ignored;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= start;
        do
            @(posedge clk);
        while (!s_tready);
        ignored = dec_ended && !start;
        decode_byte(b, start);
        if (!ignored)
            n_bytes++;
    endtask

    // byte of a random stream: start flag on the head, stray starts when broken
    task automatic stream_byte(input logic [7:0] b);
        bit start;
        start = stream_head || (broken_mode && $urandom_range(0, 15) == 0);
        stream_head = 1'b0;
        send_byte(b, start);
    endtask

    // stop offering, let every predicted beat arrive, then some quiet cycles
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write the size limit, then read it back in the next transfer
    task automatic program_size(input logic [23:0] size);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {rbd_pkg::REG_EXPECTED_SIZE, 2'b00};
        pwdata <= {8'd0, size};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        dec_size = size;
        n_sizes++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("expected_size readback", {40'd0, size}, {40'd0, prdata[23:0]});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // well-formed commands with random content, plus a little noise
    task automatic random_stream(input int n_cmds, input bit broken);
        int c;
        int k;
        int r;
        int len;
        int avail;
        stream_head = 1'b1;
        broken_mode = broken;
        no_idle = ($urandom_range(0, 4) == 0);
        for (c = 0; c < n_cmds; c++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 6);
                stream_byte(8'(len - 1));
                for (k = 0; k < len; k++)
                    stream_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 45)
                stream_byte(8'(int'(rbd_pkg::ZERO_BIAS) + pick_len(65)));
            else if (r < 62)
            begin
                stream_byte(8'(int'(rbd_pkg::RUN_BIAS) + pick_len(65)));
                stream_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 84)
            begin
                stream_byte(8'(int'(rbd_pkg::COPY_BIAS) + pick_len(63)));
                // mostly reach back inside what the stream produced so far
                avail = (dec_produced > 257) ? 257 : int'(dec_produced);
                if (!broken && avail >= 2 && $urandom_range(0, 9) != 0)
                    stream_byte(8'($urandom_range(0, avail - 2)));
                else
                    stream_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 90)
                stream_byte(rbd_pkg::CMD_NOP);
            else
                stream_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) != 0)
        begin
            stream_byte(rbd_pkg::CMD_END);
            // trailing bytes after the terminator are only status beats
            repeat ($urandom_range(0, 2)) stream_byte(8'($urandom_range(0, 255)));
        end
        no_idle = 1'b0;
        broken_mode = 1'b0;
    endtask

    // every command class, field extremes, faults and restarts
    task automatic test_directed_commands();
        program_size(24'd200);
        send_byte(8'd2, 1'b1);                          // literal run of three
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(rbd_pkg::ZERO_BIAS + 8'd65, 1'b0);    // longest zero run, nine beats
        send_byte(rbd_pkg::RUN_BIAS + 8'd65, 1'b0);     // longest repeat
        send_byte(8'h5A, 1'b0);
        send_byte(rbd_pkg::COPY_BIAS + 8'd63, 1'b0);    // copy overlapping its own output
        send_byte(8'd0, 1'b0);
        send_byte(rbd_pkg::COPY_BIAS + 8'd3, 1'b0);     // copy from before the stream start
        send_byte(8'hFF, 1'b0);
        send_byte(rbd_pkg::CMD_NOP, 1'b0);
        send_byte(rbd_pkg::ZERO_BIAS + 8'd2, 1'b0);     // fills up to 198 bytes
        send_byte(rbd_pkg::ZERO_BIAS + 8'd3, 1'b0);     // last byte crosses the size limit
        send_byte(rbd_pkg::ZERO_BIAS + 8'd2, 1'b0);     // fully dropped
        send_byte(rbd_pkg::CMD_END, 1'b0);
        send_byte(8'h12, 1'b0);                         // ignored after the end
        send_byte(8'd1, 1'b1);                          // restart
        send_byte(8'h33, 1'b0);
        send_byte(rbd_pkg::RUN_BIAS + 8'd2, 1'b1);      // restart in the middle of a literal run
        send_byte(8'h77, 1'b0);
        send_byte(rbd_pkg::COPY_BIAS + 8'd4, 1'b0);     // distance equal to bytes produced
        send_byte(8'd0, 1'b0);
        send_byte(rbd_pkg::CMD_END, 1'b0);
        wait_drained();
    endtask

    // zero size: every byte dropped; largest size: nothing dropped
    task automatic test_size_limits();
        program_size(24'd0);
        send_byte(8'd0, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(rbd_pkg::ZERO_BIAS + 8'd7, 1'b0);
        send_byte(rbd_pkg::COPY_BIAS + 8'd2, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(rbd_pkg::CMD_END, 1'b0);
        wait_drained();
        program_size(SIZE_MAX);
        random_stream(10, 1'b0);
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        int i;
        no_idle = 1'b1;
        hold_req = 1'b1;
        send_byte(rbd_pkg::ZERO_BIAS + 8'd9, 1'b1);
        for (i = 0; i < 30; i++)
            send_byte(8'(int'(rbd_pkg::ZERO_BIAS) + $urandom_range(9, 40)), 1'b0);
        send_byte(rbd_pkg::CMD_END, 1'b0);
        wait_drained();
        no_idle = 1'b0;
    endtask

    // random streams over a spread of size limits
    task automatic test_random_streams();
        int first_byte;
        int r;
        logic [23:0] size;
        first_byte = n_bytes;
        while (n_bytes - first_byte < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 3);
            case (r)
                0:       size = 24'($urandom_range(1, 40));
                1:       size = 24'($urandom_range(41, 600));
                2:       size = SIZE_MAX;
                default: size = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            program_size(size);
            repeat ($urandom_range(1, 3))
                random_stream($urandom_range(3, 12), $urandom_range(0, 9) == 0);
            wait_drained();
        end
    endtask

    // output side: random stalls, no-idle stretches, one long hold on request
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                n_holds++;
            end
            else
            begin
                gap = no_idle ? 0 : pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // every accepted beat is matched against the oldest predicted beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_beats++;
            if (pending_beats.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("unexpected beat: tdata %h tlast %b tuser %b",
                             m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                oldest = pending_beats.pop_front();
                check_field("out_data", oldest.data, m_tdata[63:0]);
                check_field("byte_count", {60'd0, oldest.count}, {60'd0, m_tdata[67:64]});
                check_field("run_last", {63'd0, oldest.last}, {63'd0, m_tlast});
                check_field("stream_end", {63'd0, oldest.ended}, {63'd0, m_tuser[0]});
                check_field("fault", {63'd0, oldest.fault}, {63'd0, m_tuser[1]});
            end
        end
    end

    // hard stop if the run hangs
    initial
    begin
        #(2 * LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_size_limits();
        test_output_backpressure();
        test_random_streams();
        wait_drained();

        $display("decoded %0d compressed bytes in %0d streams under %0d size limits",
                 n_bytes, n_streams, n_sizes);
        $display("checked %0d beats, %0d streams faulted, %0d long output holds",
                 n_beats, n_fault_streams, n_holds);
        if (n_mismatch == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
